// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int COPY_COUNT    = CELL_COUNT - SCREEN_WIDTH;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int CELL_W = 16;
  localparam int POS_OUT_W = 11;

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CHAR_BLANK};

  typedef enum logic [1:0] {
    KIND_PUT      = 2'd0,
    KIND_WRITE_AT = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_READ     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic                 load;
    logic [POS_OUT_W-1:0] cursor_position;
    logic [CELL_W-1:0]    read_data;
  } res_t;

endpackage

// ===== src/tcw_ifaces.sv =====
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_code;
  logic [6:0]  column;
  logic [10:0] read_address;

  modport source (output valid, kind, char_code, column, read_address, input ready);
  modport sink   (input valid, kind, char_code, column, read_address, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [15:0] read_data;

  modport source (output valid, cursor_position, read_data, input ready);
  modport sink   (input valid, cursor_position, read_data, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

// ===== src/text_console_writer_unit.sv =====
// Text console writer: a character-cell screen with a cursor.
// Channels:
//   in_ch  - one command item: kind, char_code, column, read_address.
//   out_ch - one result item per command: cursor_position and read_data.
//   cfg_ch - writes text_attribute; always ready, write it only while no
//     item is in flight.
// Command flow:
//   put character / write at column: result registered at accept; a new item
//     can be accepted every cycle while the output register is free.
//   read cell: the cell RAM read is registered, then ST_READ loads the result.
//   clear screen: after the accept cycle, blanks are written to every cell,
//     one cell a cycle.
//   a command that scrolls: the screen is copied up one row at one cell per
//     cycle through the RAM ports, the read data registered before each
//     write; the bottom row is filled with blanks.
// Reset: cursor goes to top-left, attribute to 7, and a clearing pass writes
//   blanks to all 2000 cells; no item is accepted during those cycles.
// Stalls: the result waits in an output register; the next item is taken as
//   soon as that register is empty or is being emptied the same cycle.
module text_console_writer_unit import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  tcw_in_if.sink   in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink  cfg_ch
);

  logic [7:0]           attr_r;
  logic                 out_valid_r;
  logic [POS_OUT_W-1:0] out_pos_r;
  logic [CELL_W-1:0]    out_data_r;
  logic                 out_free;
  logic [CELL_W-1:0]    ram_rdata;
  ram_req_t             ram_req;
  res_t                 res;

  // Attribute register: accept writes at any time.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_ch.valid) begin
      attr_r <= cfg_ch.text_attribute;
    end
  end

  // Output slot is free when empty or drained this cycle.
  assign out_free = !out_valid_r || out_ch.ready;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .attr      (attr_r),
    .out_free  (out_free),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .res       (res)
  );

  tcw_cell_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Hold the result until taken; load a new one only into a free slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_pos_r  <= res.cursor_position;
      out_data_r <= res.read_data;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.read_data       = out_data_r;

endmodule

// ===== src/tcw_cell_ram.sv =====
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_ch,
  input  logic [7:0]        attr,
  input  logic              out_free,
  input  logic [CELL_W-1:0] ram_rdata,
  output ram_req_t          ram_req,
  output res_t              res
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               inrange_r, inrange_nxt;

  kind_t              kind;
  logic               accept;
  logic               cmd_ok;
  logic               at_bottom;
  logic [COL_W-1:0]   ec;
  logic [ADDR_W-1:0]  pos;
  logic [ROW_W-1:0]   row_put;
  logic [COL_W-1:0]   col_put;
  logic               wr_put;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CELL_W-1:0]  wr_data;
  logic               scroll;
  logic [CELL_W-1:0]  blank;
  logic [ADDR_W-1:0]  pos_res;
  logic               idx_last;
  logic               idx_end;

  assign kind     = kind_t'(in_ch.kind);
  assign accept   = in_ch.valid && in_ch.ready;
  assign blank    = {attr, CHAR_BLANK};
  assign idx_last = (idx_r == CNT_W'(CELL_COUNT - 1));
  assign idx_end  = (idx_r == CNT_W'(CELL_COUNT));

  // Decode a put-character or write-at-column command against the cursor.
  always_comb begin
    ec        = (kind == KIND_WRITE_AT) ? COL_W'(in_ch.column) : col_r;
    cmd_ok    = (kind == KIND_PUT) ||
                ((kind == KIND_WRITE_AT) && !in_ch.column[0] &&
                 (int'(in_ch.column) < SCREEN_WIDTH));
    at_bottom = (int'(row_r) == SCREEN_HEIGHT - 1);
    pos       = ADDR_W'(row_r) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(ec);
    row_put   = row_r;
    col_put   = col_r;
    wr_put    = 1'b0;
    wr_addr   = pos;
    wr_data   = {attr, in_ch.char_code};
    scroll    = 1'b0;
    if (cmd_ok) begin
      col_put = ec;
      if (in_ch.char_code == CHAR_NUL) begin
        col_put = ec;
      end else if (in_ch.char_code == CHAR_LF) begin
        col_put = '0;
        if (at_bottom) begin
          scroll = 1'b1;
        end else begin
          row_put = row_r + 1'b1;
        end
      end else if (in_ch.char_code == CHAR_BS) begin
        if (ec == '0) begin
          if (row_r != '0) begin
            row_put = row_r - 1'b1;
            col_put = COL_W'(SCREEN_WIDTH - 1);
          end
        end else begin
          col_put = ec - 1'b1;
          wr_put  = 1'b1;
          wr_addr = pos - 1'b1;
          wr_data = blank;
        end
      end else begin
        wr_put = 1'b1;
        if (int'(ec) == SCREEN_WIDTH - 1) begin
          col_put = '0;
          if (at_bottom) begin
            scroll = 1'b1;
          end else begin
            row_put = row_r + 1'b1;
          end
        end else begin
          col_put = ec + 1'b1;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (idx_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_PUT, KIND_WRITE_AT: state_nxt = scroll ? ST_SCROLL : ST_IDLE;
            KIND_CLEAR:              state_nxt = ST_CLEAR;
            KIND_READ:               state_nxt = ST_READ;
            default:                 state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_SCROLL: begin
        if (idx_end) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (idx_last) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_INIT;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ch.ready   = 1'b0;
    ram_req       = '0;
    res.load      = 1'b0;
    res.read_data = '0;
    row_nxt       = row_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    inrange_nxt   = inrange_r;
    unique case (state_r)
      ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r[ADDR_W-1:0];
        ram_req.wdata = RESET_BLANK;
        idx_nxt       = idx_last ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        in_ch.ready = out_free;
        if (accept) begin
          idx_nxt = '0;
          unique case (kind)
            KIND_PUT, KIND_WRITE_AT: begin
              row_nxt       = row_put;
              col_nxt       = col_put;
              ram_req.we    = wr_put;
              ram_req.waddr = wr_addr;
              ram_req.wdata = wr_data;
              res.load      = !scroll;
            end
            KIND_CLEAR: begin
              idx_nxt = '0;
            end
            KIND_READ: begin
              ram_req.re    = 1'b1;
              ram_req.raddr = ADDR_W'(in_ch.read_address);
              inrange_nxt   = (int'(in_ch.read_address) < CELL_COUNT);
            end
            default: begin
              idx_nxt = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        res.load      = 1'b1;
        res.read_data = inrange_r ? ram_rdata : '0;
      end
      ST_SCROLL: begin
        // Read the cell one row down while writing back the one read last cycle;
        // the read runs a full row ahead, so the two never hit the same entry.
        if (int'(idx_r) < COPY_COUNT) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ADDR_W'(idx_r + CNT_W'(SCREEN_WIDTH));
        end
        if (idx_r != '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = ADDR_W'(idx_r - 1'b1);
          ram_req.wdata = (int'(idx_r) <= COPY_COUNT) ? ram_rdata : blank;
        end
        idx_nxt  = idx_end ? '0 : idx_r + 1'b1;
        res.load = idx_end;
      end
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r[ADDR_W-1:0];
        ram_req.wdata = blank;
        idx_nxt       = idx_last ? '0 : idx_r + 1'b1;
        res.load      = idx_last;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
    pos_res             = ADDR_W'(row_nxt) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_nxt);
    res.cursor_position = POS_OUT_W'(pos_res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      idx_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
      inrange_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      inrange_r <= inrange_nxt;
    end
  end

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(row_r) < SCREEN_HEIGHT) && (int'(col_r) < SCREEN_WIDTH))
    else $error("cursor outside screen");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> out_free)
    else $error("result loaded while output slot busy");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !ram_req.we)
    else $error("cell write during read");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL) |-> (int'(row_r) == SCREEN_HEIGHT - 1) && (col_r == '0))
    else $error("scroll with cursor off the bottom line start");

endmodule
